FILE: rtl/core/vtesb_pkg.sv
// Shared types and constants for the escape sequence builder.
// Depends on nothing; every other file in rtl/core imports it.
package vtesb_pkg;

   localparam int unsigned MAX_DIGITS = 10;
   localparam int unsigned DIG_IDX_W  = $clog2(MAX_DIGITS);

   localparam logic [7:0] ESC_BYTE    = 8'h1B;
   localparam logic [7:0] CSI_BYTE    = 8'h5B;
   localparam logic [7:0] SEP_BYTE    = 8'h3B;
   localparam logic [7:0] MINUS_BYTE  = 8'h2D;
   localparam logic [7:0] DIGIT0_BYTE = 8'h30;

   // reciprocal of ten: floor(n * RECIP10 / 2^35) == n / 10 for any 32-bit n
   localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
   localparam int unsigned RECIP10_SHIFT = 35;

   localparam logic [2:0] OP_PRINT  = 3'd0;
   localparam logic [2:0] OP_ESCAPE = 3'd1;
   localparam logic [2:0] OP_PARAM  = 3'd2;
   localparam logic [2:0] OP_FINAL  = 3'd3;

   typedef enum logic [1:0] {
      K_PRINT,
      K_ESCAPE,
      K_PARAM,
      K_FINAL
   } kind_type;

   typedef struct packed {
      kind_type                          kind;
      logic [7:0]                        char_code;
      logic                              prefix;   // ESC '[' opens this transaction
      logic                              negative;
      logic [MAX_DIGITS-1:0][3:0]        digits;   // least significant first
      logic [DIG_IDX_W-1:0]              top_digit;
   } entry_type;

   typedef enum logic [0:0] {
      F_IDLE,
      F_CONVERT
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_ESC,
      B_CSI,
      B_SEP,
      B_MINUS,
      B_DIGIT,
      B_CHAR
   } back_state_type;

endpackage

FILE: rtl/core/vt_escape_sequence_builder.sv
// Top level of the terminal escape sequence builder.
// Instantiates vtesb_front, vtesb_queue and vtesb_back; uses vtesb_pkg.
//
// One input transaction carries a terminal action; the block answers with
// the output bytes of that action, one byte per result transaction, with
// rsp_tlast high on the final byte of each action. Print gives the
// character; escape dispatch gives ESC and the character; a parameter
// gives ESC '[' (first of a sequence) or ';' (later ones), an optional
// '-' and the decimal digits without leading zeros; a final gives the
// character, preceded by ESC '[' when no parameter came. Ignored and
// unused opcodes give nothing. Timing: the back end emits one byte per
// cycle while the output is not stalled, an action has 1 to 13 bytes,
// and consecutive actions stream without gaps. A parameter holds the
// input until its 1 to 10 digits are produced, while the front end's
// reciprocal multiplier peels off one decimal digit per cycle; this
// overlaps with the back end draining earlier actions through the queue,
// so the back end's one byte per cycle sets the sustained rate.
module vt_escape_sequence_builder
   import vtesb_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [7:0] char_code, [39:8] param_value
   input  logic [2:0]  req_tuser,   // [2:0] opcode
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast    // last_of_run
);

   logic      push_valid, push_ready;
   entry_type push_data;
   logic      pop_valid, pop_ready;
   entry_type pop_data;

   // classify actions and convert parameters to digits
   vtesb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // decouple conversion from byte emission
   vtesb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // emit bytes through the registered output stage
   vtesb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: rtl/core/vtesb_front.sv
// Front end: accepts actions, tracks the open-sequence flag and converts
// parameters to decimal digits, one digit per cycle. Uses vtesb_pkg.
module vtesb_front
   import vtesb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic [2:0]  req_tuser,
   output logic        push_valid,
   input  logic        push_ready,
   output entry_type   push_data
);

   front_state_type      state_ff, state_in;
   logic                 hold_valid_ff, hold_valid_in;
   entry_type            hold_ff, hold_in;
   logic                 seq_open_ff, seq_open_in;
   logic [31:0]          mag_ff, mag_in;
   logic [DIG_IDX_W-1:0] dig_cnt_ff, dig_cnt_in;

   logic [63:0] prod;
   logic [31:0] quot;
   logic [31:0] rem_full;
   logic [31:0] pval;
   logic        accept;

   assign pval     = req_tdata[39:8];
   assign prod     = {32'd0, mag_ff} * {32'd0, RECIP10};
   assign quot     = {3'd0, prod[63:RECIP10_SHIFT]};
   assign rem_full = mag_ff - ((quot << 3) + (quot << 1));

   assign push_valid = hold_valid_ff;
   assign push_data  = hold_ff;
   assign req_tready = (state_ff == F_IDLE) && (!hold_valid_ff || push_ready);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= F_IDLE;
         hold_valid_ff <= 1'b0;
         seq_open_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
         seq_open_ff   <= seq_open_in;
      end
      hold_ff    <= hold_in;
      mag_ff     <= mag_in;
      dig_cnt_ff <= dig_cnt_in;
   end

   always_comb begin
      state_in      = state_ff;
      hold_valid_in = hold_valid_ff && !push_ready;
      hold_in       = hold_ff;
      seq_open_in   = seq_open_ff;
      mag_in        = mag_ff;
      dig_cnt_in    = dig_cnt_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               hold_in.char_code = req_tdata[7:0];
               hold_in.prefix    = !seq_open_ff;
               hold_in.negative  = 1'b0;
               case (req_tuser)
                  OP_PRINT: begin
                     hold_in.kind  = K_PRINT;
                     hold_valid_in = 1'b1;
                  end
                  OP_ESCAPE: begin
                     hold_in.kind  = K_ESCAPE;
                     hold_valid_in = 1'b1;
                  end
                  OP_PARAM: begin
                     hold_in.kind     = K_PARAM;
                     hold_in.negative = pval[31];
                     mag_in           = pval[31] ? (32'd0 - pval) : pval;
                     dig_cnt_in       = '0;
                     seq_open_in      = 1'b1;
                     state_in         = F_CONVERT;
                  end
                  OP_FINAL: begin
                     hold_in.kind  = K_FINAL;
                     seq_open_in   = 1'b0;
                     hold_valid_in = 1'b1;
                  end
                  default: begin
                     // drop ignored and unused actions
                  end
               endcase
            end
         end
         F_CONVERT: begin
            hold_in.digits[dig_cnt_ff] = rem_full[3:0];
            if (quot == 32'd0) begin
               hold_in.top_digit = dig_cnt_ff;
               hold_valid_in     = 1'b1;
               state_in          = F_IDLE;
            end else begin
               mag_in     = quot;
               dig_cnt_in = dig_cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/vtesb_queue.sv
// Small register queue of classified actions between front and back end.
// Uses vtesb_pkg for the entry type.
module vtesb_queue
   import vtesb_pkg::*;
#(
   parameter int unsigned DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_data,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign push_ready = (cnt_ff != CNT_W'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/vtesb_back.sv
// Back end: walks one queued action byte by byte into the output register.
// Uses vtesb_pkg for the entry and state types.
module vtesb_back
   import vtesb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       pop_valid,
   output logic       pop_ready,
   input  entry_type  pop_data,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast
);

   back_state_type       state_ff, state_in;
   entry_type            cur_ff, cur_in;
   logic [DIG_IDX_W-1:0] idx_ff, idx_in;
   logic                 out_valid_ff, out_valid_in;
   logic [7:0]           out_byte_ff, out_byte_in;
   logic                 out_last_ff, out_last_in;

   logic                 can_emit;
   logic                 emit;
   logic                 emit_last;
   logic [7:0]           emit_byte;
   back_state_type       after;
   back_state_type       start;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign can_emit   = !out_valid_ff || rsp_tready;

   always_comb begin
      case (pop_data.kind)
         K_PRINT:  start = B_CHAR;
         K_ESCAPE: start = B_ESC;
         K_PARAM:  start = pop_data.prefix ? B_ESC : B_SEP;
         K_FINAL:  start = pop_data.prefix ? B_ESC : B_CHAR;
         default:  start = B_CHAR;
      endcase
   end

   always_comb begin
      emit      = 1'b0;
      emit_last = 1'b0;
      emit_byte = cur_ff.char_code;
      after     = state_ff;
      idx_in    = idx_ff;
      case (state_ff)
         B_IDLE: begin
         end
         B_ESC: begin
            emit      = can_emit;
            emit_byte = ESC_BYTE;
            after     = (cur_ff.kind == K_ESCAPE) ? B_CHAR : B_CSI;
         end
         B_CSI: begin
            emit      = can_emit;
            emit_byte = CSI_BYTE;
            if (cur_ff.kind == K_PARAM) begin
               after = cur_ff.negative ? B_MINUS : B_DIGIT;
            end else begin
               after = B_CHAR;
            end
         end
         B_SEP: begin
            emit      = can_emit;
            emit_byte = SEP_BYTE;
            after     = cur_ff.negative ? B_MINUS : B_DIGIT;
         end
         B_MINUS: begin
            emit      = can_emit;
            emit_byte = MINUS_BYTE;
            after     = B_DIGIT;
         end
         B_DIGIT: begin
            emit      = can_emit;
            emit_byte = DIGIT0_BYTE + {4'd0, cur_ff.digits[idx_ff]};
            emit_last = (idx_ff == '0);
            if (can_emit && idx_ff != '0) begin
               idx_in = idx_ff - 1'b1;
            end
         end
         B_CHAR: begin
            emit      = can_emit;
            emit_last = 1'b1;
         end
         default: begin
            after = B_IDLE;
         end
      endcase

      state_in  = emit ? after : state_ff;
      cur_in    = cur_ff;
      pop_ready = 1'b0;
      // load the next transaction when idle or right on the closing byte
      if ((state_ff == B_IDLE) || (emit && emit_last)) begin
         pop_ready = pop_valid;
         if (pop_valid) begin
            cur_in   = pop_data;
            idx_in   = pop_data.top_digit;
            state_in = start;
         end else begin
            state_in = B_IDLE;
         end
      end

      out_valid_in = out_valid_ff && !rsp_tready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         out_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

endmodule

FILE: rtl/core/vtesb_checker.sv
// Port-level checks for the escape sequence builder, bound to its top.
// Uses vtesb_pkg for the opcode codes.
module vtesb_checker
   import vtesb_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);

   // no result is offered right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result holds its byte and last flag
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result changed");

   // a parameter keeps the input busy while its digits are produced
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == OP_PARAM) |=> !req_tready)
      else $error("input ready during digit conversion");

endmodule

bind vt_escape_sequence_builder vtesb_checker u_checker (.*);

FILE: test/vt_escape_sequence_builder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for vt_escape_sequence_builder: directed and random
// terminal actions, bytes predicted in the bench and compared in order.
// Depends on vtesb_pkg for the opcodes and the fixed sequence bytes.
module vt_escape_sequence_builder_tb;
   import vtesb_pkg::*;

   // opcodes the package leaves unnamed: one ignored action, three unused codes
   localparam logic [2:0] OP_IGNORED   = 3'd4;
   localparam logic [2:0] OP_UNUSED_LO = 3'd5;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 40;
   localparam int PHASE_ITEMS    = 64;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  char_code;
      logic [31:0] param_value;
   } action_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } seq_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // [7:0] char_code, [39:8] param_value
   logic [2:0]  req_tuser = '0;   // [2:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [7:0] out_byte
   logic        rsp_tlast;        // last_of_run

   action_type   pending_actions[$];
   seq_byte_type expected_bytes[$];
   logic         csi_open = 1'b0;    // bench copy of the open-sequence flag
   int           error_count = 0;
   int           stall_cycles = 0;
   int           sender_idle_pct = 22;
   int           receiver_idle_pct = 86;

   vt_escape_sequence_builder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Prediction: append the bytes one action produces to expected_bytes
   // ---------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b);
      seq_byte_type e;
      e.out_byte    = b;
      e.last_of_run = 1'b0;
      expected_bytes.push_back(e);
   endtask

   // signed decimal, no leading zeros; magnitude taken modulo 2^32
   task automatic push_decimal(input logic [31:0] raw);
      logic [3:0]  digit_buf[10];
      logic [31:0] mag;
      int          nd;
      nd  = 0;
      mag = raw[31] ? (32'd0 - raw) : raw;
      do begin
         digit_buf[nd] = 4'(mag % 32'd10);
         nd++;
         mag = mag / 32'd10;
      end while (mag != 0 && nd < 10);
      if (raw[31])
         push_byte(MINUS_BYTE);
      while (nd > 0) begin
         nd--;
         push_byte(DIGIT0_BYTE + {4'd0, digit_buf[nd]});
      end
   endtask

   task automatic predict_action(input logic [2:0] op, input logic [7:0] ch,
                                 input logic [31:0] value);
      int before_size;
      before_size = expected_bytes.size();
      case (op)
         OP_PRINT: push_byte(ch);
         OP_ESCAPE: begin
            push_byte(ESC_BYTE);
            push_byte(ch);
         end
         OP_PARAM: begin
            // later parameters are separated, the first one opens the sequence
            if (csi_open) begin
               push_byte(SEP_BYTE);
            end else begin
               push_byte(ESC_BYTE);
               push_byte(CSI_BYTE);
            end
            push_decimal(value);
            csi_open = 1'b1;
         end
         OP_FINAL: begin
            // a final with no parameter still needs its own introducer
            if (!csi_open) begin
               push_byte(ESC_BYTE);
               push_byte(CSI_BYTE);
            end
            push_byte(ch);
            csi_open = 1'b0;
         end
         default: ;  // ignored and unused opcodes: no bytes, state kept
      endcase
      if (expected_bytes.size() > before_size)
         expected_bytes[expected_bytes.size() - 1].last_of_run = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_action(input logic [2:0] op, input logic [7:0] ch,
                               input logic [31:0] value);
      action_type a;
      a.opcode      = op;
      a.char_code   = ch;
      a.param_value = value;
      pending_actions.push_back(a);
   endtask

   // spread the digit count: mostly short values, some full width, extremes
   function automatic logic [31:0] pick_param_value();
      logic [31:0] v;
      case ($urandom_range(0, 5))
         0: v = $urandom_range(0, 9);
         1: v = $urandom_range(10, 9999);
         2: v = $urandom;
         3: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         4: v = $urandom_range(100000, 2000000000);
         default: v = $urandom_range(1, 99);
      endcase
      if ($urandom_range(0, 2) == 0)
         v = 32'd0 - v;
      return v;
   endfunction

   // usual final bytes half of the time, any byte otherwise
   function automatic logic [7:0] pick_final_char();
      if ($urandom_range(0, 1))
         return 8'($urandom_range(8'h40, 8'h7E));
      return 8'($urandom_range(0, 255));
   endfunction

   // mostly well-formed control sequences, with plain actions, noise and
   // broken sequences mixed in; ignored opcodes do not count toward target
   task automatic add_random_traffic(input int target);
      int made;
      int pick;
      int n_params;
      made = 0;
      while (made < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 18) begin
            queue_action(OP_PRINT, 8'($urandom_range(0, 255)), $urandom);
            made++;
         end else if (pick < 30) begin
            queue_action(OP_ESCAPE, 8'($urandom_range(0, 255)), $urandom);
            made++;
         end else if (pick < 80) begin
            n_params = $urandom_range(0, 4);
            for (int i = 0; i < n_params; i++) begin
               // occasionally interleave a plain action inside the sequence
               if ($urandom_range(0, 9) == 0) begin
                  queue_action($urandom_range(0, 1) ? OP_PRINT : OP_ESCAPE,
                               8'($urandom_range(0, 255)), $urandom);
                  made++;
               end
               queue_action(OP_PARAM, 8'($urandom_range(0, 255)), pick_param_value());
               made++;
            end
            queue_action(OP_FINAL, pick_final_char(), $urandom);
            made++;
         end else if (pick < 90) begin
            queue_action(3'($urandom_range(OP_IGNORED, OP_UNUSED_HI)),
                         8'($urandom_range(0, 255)), $urandom);
         end else if (pick < 95) begin
            // parameters left dangling; the next sequence continues them
            queue_action(OP_PARAM, 8'($urandom_range(0, 255)), pick_param_value());
            made++;
         end else begin
            queue_action(OP_FINAL, 8'($urandom_range(0, 255)), $urandom);
            made++;
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_actions.size() != 0 || req_tvalid || expected_bytes.size() != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Driver: present pending actions, idle and stall at the phase's rates
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      action_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
         // hold a transaction that is still waiting; otherwise advance
         if (!req_tvalid || req_tready) begin
            if (pending_actions.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               nxt = pending_actions.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {nxt.param_value, nxt.char_code};
               req_tuser  <= nxt.opcode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on each accepted action, check each accepted byte
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      seq_byte_type want;
      if (reset) begin
         csi_open = 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            predict_action(req_tuser, req_tdata[7:0], req_tdata[39:8]);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected transaction: out_byte %h last_of_run %b",
                      rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_tdata !== want.out_byte) begin
                  $error("out_byte: expected %h, actual %h", want.out_byte, rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast !== want.last_of_run) begin
                  $error("last_of_run: expected %b, actual %b",
                         want.last_of_run, rsp_tlast);
                  error_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: count cycles with work outstanding and no transaction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (pending_actions.size() == 0 && !req_tvalid && expected_bytes.size() == 0)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("vt_escape_sequence_builder_tb: errors");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // character extremes for print and escape dispatch
      queue_action(OP_PRINT, 8'h00, 32'h0);
      queue_action(OP_PRINT, 8'hFF, 32'hFFFF_FFFF);
      queue_action(OP_ESCAPE, 8'h00, 32'h0);
      queue_action(OP_ESCAPE, 8'hFF, 32'h0);
      // final with no parameter before it
      queue_action(OP_FINAL, 8'h6D, 32'h0);
      // one sequence through the value extremes, most negative included
      queue_action(OP_PARAM, 8'h00, 32'd0);
      queue_action(OP_PARAM, 8'hFF, 32'h7FFF_FFFF);
      queue_action(OP_PARAM, 8'h00, 32'h8000_0001);
      queue_action(OP_PARAM, 8'h00, 32'h8000_0000);
      queue_action(OP_PARAM, 8'h00, 32'hFFFF_FFFF);
      queue_action(OP_PARAM, 8'h00, 32'd9);
      queue_action(OP_PARAM, 8'h00, 32'd10);
      queue_action(OP_FINAL, 8'h48, 32'h0);
      // print and escape inside an open sequence keep it open
      queue_action(OP_PARAM, 8'h00, 32'd5);
      queue_action(OP_PRINT, 8'h61, 32'h0);
      queue_action(OP_ESCAPE, 8'h62, 32'h0);
      // ignored and unused opcodes inside a sequence leave it open
      queue_action(OP_IGNORED, 8'hFF, 32'hFFFF_FFFF);
      queue_action(OP_UNUSED_LO, 8'h00, 32'h0);
      queue_action(OP_PARAM, 8'h00, 32'd7);
      queue_action(OP_UNUSED_HI, 8'hFF, 32'hFFFF_FFFF);
      queue_action(OP_FINAL, 8'h00, 32'h0);
      // ignored and unused opcodes outside a sequence
      queue_action(3'd6, 8'hA5, 32'h5A5A_5A5A);
      queue_action(OP_IGNORED, 8'h00, 32'h0);
      queue_action(OP_FINAL, 8'hFF, 32'hFFFF_FFFF);

      // phase one: sender idles lightly, receiver stalls heavily
      add_random_traffic(PHASE_ITEMS);
      wait_drained();

      // phase two: the other way round
      @(negedge clock);
      sender_idle_pct   = 86;
      receiver_idle_pct = 22;
      add_random_traffic(PHASE_ITEMS);
      wait_drained();

      // phase three: full rate on both sides
      @(negedge clock);
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      add_random_traffic(PHASE_ITEMS);
      wait_drained();

      // let any stray byte show up before the verdict
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("vt_escape_sequence_builder_tb: clean");
      end else begin
         $display("vt_escape_sequence_builder_tb: errors");
      end
      $finish;
   end

endmodule
